// ===== rtl/core/bmhq_pkg.sv =====
// Shared types, sizes and codes of the binary min-heap priority queue.
package bmhq_pkg;

    // Heap size and priority width.
    localparam int CAPACITY       = 1024;
    localparam int PRIORITY_WIDTH = 16;

    // Field widths of the words.
    localparam int KEY_W    = 16;
    localparam int PRIO_IO_W = 16;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 11;

    // Derived storage widths.
    localparam int PRIO_W  = (PRIORITY_WIDTH < PRIO_IO_W) ? PRIORITY_WIDTH : PRIO_IO_W;
    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int CHILD_W = ADDR_W + 2;

    // Operation codes carried in s_tuser.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Result status codes carried in m_tuser.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_PUSHED     = 2'd0,
        STATUS_POPPED     = 2'd1,
        STATUS_PUSH_FULL  = 2'd2,
        STATUS_POP_EMPTY  = 2'd3
    } status_t;

    // One heap entry as held in the store.
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [KEY_W-1:0]  key;
    } entry_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH_CMP,
        ST_POP_LOAD,
        ST_POP_CMP,
        ST_PLACE,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/core/binary_min_heap_queue_unit.sv =====
// Binary min-heap priority queue: store, sift sequencer and result register.
//
//  channel  direction  handshake           payload
//  s_       in         s_tvalid/s_tready   tuser: cmd; tdata: key, priority
//  m_       out        m_tvalid/m_tready   tuser: status; tdata: key, priority, fill count
//
// A push compares the moving entry against one parent per level it climbs; a pop first
// loads the root and the last entry, then compares against the children per level it sinks.
// The heap store's reads are registered, and the sift moves one level per cycle.
// Reset clears the fill count and the sequencer; the store itself is not cleared.
// A new word is taken only while the sequencer is idle; a finished result waits in the
// output register, and the sequencer holds in its done state while that register is full.
module binary_min_heap_queue_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] entry_key, [31:16] entry_priority
    input  logic [0:0]  s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] out_key, [31:16] out_priority, [42:32] fill_count
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int ADDR_W  = bmhq_pkg::ADDR_W;
    localparam int COUNT_W = bmhq_pkg::COUNT_W;
    localparam int CHILD_W = bmhq_pkg::CHILD_W;
    localparam int PRIO_W  = bmhq_pkg::PRIO_W;
    localparam int KEY_W   = bmhq_pkg::KEY_W;

    // Index of the parent of a heap slot.
    function automatic logic [ADDR_W-1:0] parent_of(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] t;
        t = a - ADDR_W'(1);
        return t >> 1;
    endfunction

    // Index of the left child of a heap slot, wide enough to reach past the end.
    function automatic logic [CHILD_W-1:0] left_of(input logic [ADDR_W-1:0] a);
        return {1'b0, a, 1'b1};
    endfunction

    // Control state.
    bmhq_pkg::state_t  state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // Sift and result payload.
    logic [ADDR_W-1:0]  hole_reg, hole_next;
    bmhq_pkg::entry_t   mov_reg, mov_next;
    logic [KEY_W-1:0]   res_key_reg, res_key_next;
    logic [PRIO_W-1:0]  res_prio_reg, res_prio_next;
    bmhq_pkg::status_t  res_status_reg, res_status_next;
    logic [KEY_W-1:0]   m_key_reg, m_key_next;
    logic [PRIO_W-1:0]  m_prio_reg, m_prio_next;
    bmhq_pkg::status_t  m_status_reg, m_status_next;
    logic [COUNT_W-1:0] m_fill_reg, m_fill_next;

    // Heap store with one write port and two registered read ports.
    bmhq_pkg::entry_t   mem [bmhq_pkg::CAPACITY];
    bmhq_pkg::entry_t   rd_a_reg, rd_b_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    bmhq_pkg::entry_t   mem_wdata;
    logic [ADDR_W-1:0]  rd_a_addr, rd_b_addr;

    // Handshake terms.
    logic s_acc, out_free;
    assign s_tready = (state_reg == bmhq_pkg::ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Compare terms of the sift steps.
    logic               push_full, pop_empty, push_at_root;
    logic [ADDR_W-1:0]  push_parent, up_parent, up_grand;
    logic               up_move;
    logic [CHILD_W-1:0] cnt_ext, dn_left, dn_right, nx_left;
    logic               right_ok, take_r, take_l, dn_move;
    logic [PRIO_W-1:0]  best_prio;
    logic [ADDR_W-1:0]  dn_best;
    logic               nx_has_child;

    assign cnt_ext      = CHILD_W'(count_reg);
    assign push_full    = (count_reg >= COUNT_W'(bmhq_pkg::CAPACITY));
    assign pop_empty    = (count_reg == '0);
    assign push_at_root = (count_reg == '0);
    assign push_parent  = parent_of(count_reg[ADDR_W-1:0]);

    // Sift-up: the moving entry climbs on a strict less-than.
    assign up_parent = parent_of(hole_reg);
    assign up_grand  = parent_of(up_parent);
    assign up_move   = (mov_reg.prio < rd_a_reg.prio);

    // Sift-down: right child first, the left child wins only when strictly smaller.
    assign dn_left   = left_of(hole_reg);
    assign dn_right  = dn_left + CHILD_W'(1);
    assign right_ok  = (dn_right < cnt_ext);
    assign take_r    = right_ok && (rd_b_reg.prio < mov_reg.prio);
    assign best_prio = take_r ? rd_b_reg.prio : mov_reg.prio;
    assign take_l    = (rd_a_reg.prio < best_prio);
    assign dn_move   = take_l || take_r;
    assign dn_best   = take_l ? dn_left[ADDR_W-1:0] : dn_right[ADDR_W-1:0];
    assign nx_left   = left_of(dn_best);
    assign nx_has_child = (nx_left < cnt_ext);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bmhq_pkg::ST_IDLE: begin
                if (s_acc) begin
                    if (s_tuser[0] == bmhq_pkg::CMD_PUSH) begin
                        if (push_full) begin
                            state_next = bmhq_pkg::ST_DONE;
                        end else if (push_at_root) begin
                            state_next = bmhq_pkg::ST_PLACE;
                        end else begin
                            state_next = bmhq_pkg::ST_PUSH_CMP;
                        end
                    end else begin
                        state_next = pop_empty ? bmhq_pkg::ST_DONE : bmhq_pkg::ST_POP_LOAD;
                    end
                end
            end
            bmhq_pkg::ST_PUSH_CMP: begin
                if (!up_move) begin
                    state_next = bmhq_pkg::ST_DONE;
                end else if (up_parent == '0) begin
                    state_next = bmhq_pkg::ST_PLACE;
                end
            end
            bmhq_pkg::ST_POP_LOAD: begin
                if (count_reg == '0) begin
                    state_next = bmhq_pkg::ST_DONE;
                end else if (CHILD_W'(1) < cnt_ext) begin
                    state_next = bmhq_pkg::ST_POP_CMP;
                end else begin
                    state_next = bmhq_pkg::ST_PLACE;
                end
            end
            bmhq_pkg::ST_POP_CMP: begin
                if (!dn_move) begin
                    state_next = bmhq_pkg::ST_DONE;
                end else if (!nx_has_child) begin
                    state_next = bmhq_pkg::ST_PLACE;
                end
            end
            bmhq_pkg::ST_PLACE: begin
                state_next = bmhq_pkg::ST_DONE;
            end
            bmhq_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = bmhq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bmhq_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath, store accesses and result register.
    always_comb begin
        count_next      = count_reg;
        hole_next       = hole_reg;
        mov_next        = mov_reg;
        res_key_next    = res_key_reg;
        res_prio_next   = res_prio_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_key_next      = m_key_reg;
        m_prio_next     = m_prio_reg;
        m_status_next   = m_status_reg;
        m_fill_next     = m_fill_reg;
        mem_we          = 1'b0;
        mem_waddr       = hole_reg;
        mem_wdata       = mov_reg;
        rd_a_addr       = '0;
        rd_b_addr       = '0;
        unique case (state_reg)
            bmhq_pkg::ST_IDLE: begin
                res_key_next  = '0;
                res_prio_next = '0;
                if (s_acc) begin
                    if (s_tuser[0] == bmhq_pkg::CMD_PUSH) begin
                        if (push_full) begin
                            res_status_next = bmhq_pkg::STATUS_PUSH_FULL;
                        end else begin
                            res_status_next = bmhq_pkg::STATUS_PUSHED;
                            count_next      = count_reg + COUNT_W'(1);
                            hole_next       = count_reg[ADDR_W-1:0];
                            mov_next.key    = s_tdata[15:0];
                            mov_next.prio   = s_tdata[16 +: PRIO_W];
                            rd_a_addr       = push_parent;
                        end
                    end else begin
                        if (pop_empty) begin
                            res_status_next = bmhq_pkg::STATUS_POP_EMPTY;
                            count_next      = '0;
                        end else begin
                            res_status_next = bmhq_pkg::STATUS_POPPED;
                            count_next      = count_reg - COUNT_W'(1);
                            rd_a_addr       = '0;
                            rd_b_addr       = count_next[ADDR_W-1:0];
                        end
                    end
                end
            end
            bmhq_pkg::ST_PUSH_CMP: begin
                if (up_move) begin
                    mem_we    = 1'b1;
                    mem_wdata = rd_a_reg;
                    hole_next = up_parent;
                    rd_a_addr = up_grand;
                end else begin
                    mem_we = 1'b1;
                end
            end
            bmhq_pkg::ST_POP_LOAD: begin
                res_key_next  = rd_a_reg.key;
                res_prio_next = rd_a_reg.prio;
                mov_next      = rd_b_reg;
                hole_next     = '0;
                rd_a_addr     = ADDR_W'(1);
                rd_b_addr     = ADDR_W'(2);
            end
            bmhq_pkg::ST_POP_CMP: begin
                mem_we = 1'b1;
                if (dn_move) begin
                    mem_wdata = take_l ? rd_a_reg : rd_b_reg;
                    hole_next = dn_best;
                    rd_a_addr = nx_left[ADDR_W-1:0];
                    rd_b_addr = nx_left[ADDR_W-1:0] + ADDR_W'(1);
                end
            end
            bmhq_pkg::ST_PLACE: begin
                mem_we = 1'b1;
            end
            bmhq_pkg::ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_key_next    = res_key_reg;
                    m_prio_next   = res_prio_reg;
                    m_status_next = res_status_reg;
                    m_fill_next   = count_reg;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bmhq_pkg::ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        hole_reg       <= hole_next;
        mov_reg        <= mov_next;
        res_key_reg    <= res_key_next;
        res_prio_reg   <= res_prio_next;
        res_status_reg <= res_status_next;
        m_key_reg      <= m_key_next;
        m_prio_reg     <= m_prio_next;
        m_status_reg   <= m_status_next;
        m_fill_reg     <= m_fill_next;
    end

    // Heap store.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    // Output word.
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, bmhq_pkg::FILL_W'(m_fill_reg),
                       bmhq_pkg::PRIO_IO_W'(m_prio_reg), m_key_reg};
    assign m_tuser  = m_status_reg;

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(bmhq_pkg::CAPACITY))
        else $error("fill count above capacity");

    // The store is never written while the sequencer is idle.
    a_no_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bmhq_pkg::ST_IDLE) |-> !mem_we)
        else $error("store write while idle");

    // A climbing entry never sits at the root while comparing against a parent.
    a_push_hole: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bmhq_pkg::ST_PUSH_CMP) |-> (hole_reg != '0))
        else $error("sift-up compare at the root");

    // A pop of an empty heap reports the empty status.
    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tuser[0] == bmhq_pkg::CMD_POP && count_reg == '0) |=>
        (res_status_reg == bmhq_pkg::STATUS_POP_EMPTY))
        else $error("empty pop not flagged");

    // A new result word appears only out of the done state.
    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == bmhq_pkg::ST_DONE))
        else $error("result word outside the done state");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench of the binary min-heap priority queue unit.
`timescale 1ns / 100ps

module testbench;

    // Idle cycles without any accepted word before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;
    // Cycles allowed after the last result for stray words to show up.
    localparam int TAIL_CYCLES    = 40;

    // One command word queued for the driver.
    typedef struct {
        logic        cmd;
        logic [15:0] key;
        logic [15:0] prio;
        bit          drain_first;
        bit          no_gap;
    } command_t;

    // One predicted result word.
    typedef struct {
        logic [15:0]       key;
        logic [15:0]       prio;
        bmhq_pkg::status_t status;
        logic [10:0]       fill;
    } heap_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = bmhq_pkg::CMD_PUSH;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    command_t     command_queue[$];
    heap_result_t heap_results_due[$];

    // Mirror of the heap contents as the block should hold them.
    logic [bmhq_pkg::KEY_W-1:0]  mirror_key[bmhq_pkg::CAPACITY];
    logic [bmhq_pkg::PRIO_W-1:0] mirror_prio[bmhq_pkg::CAPACITY];
    int                          mirror_count = 0;

    int mismatch_count = 0;
    int send_gap       = 0;
    int ready_stall    = 0;
    bit ready_calm     = 1'b0;
    int cycle_count    = 0;
    int idle_cycles    = 0;

    binary_min_heap_queue_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [15:0] entry_key, [31:16] entry_priority
        .s_tuser  (s_tuser),   // [0] cmd
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [15:0] out_key, [31:16] out_priority, [42:32] fill_count
        .m_tuser  (m_tuser)    // [1:0] status
    );

    // Free-running clock.
    always #4 aclk = ~aclk;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Swap two slots of the mirrored heap.
    task automatic mirror_swap(input int a, input int b);
        logic [bmhq_pkg::KEY_W-1:0]  k;
        logic [bmhq_pkg::PRIO_W-1:0] p;
        k = mirror_key[a];
        p = mirror_prio[a];
        mirror_key[a]  = mirror_key[b];
        mirror_prio[a] = mirror_prio[b];
        mirror_key[b]  = k;
        mirror_prio[b] = p;
    endtask

    // Apply one accepted command to the mirror and queue the result it must produce.
    task automatic predict_heap_op(input logic cmd, input logic [15:0] key,
                                   input logic [15:0] prio);
        heap_result_t res;
        int pos, parent, best, left, right;
        bit moving;
        res.key  = '0;
        res.prio = '0;
        if (cmd == bmhq_pkg::CMD_PUSH) begin
            if (mirror_count >= bmhq_pkg::CAPACITY) begin
                res.status = bmhq_pkg::STATUS_PUSH_FULL;
            end else begin
                pos = mirror_count;
                mirror_key[pos]  = key;
                mirror_prio[pos] = prio[bmhq_pkg::PRIO_W-1:0];
                // Sift up only on a strictly smaller priority.
                moving = 1'b1;
                while (moving && pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (mirror_prio[pos] < mirror_prio[parent]) begin
                        mirror_swap(pos, parent);
                        pos = parent;
                    end else begin
                        moving = 1'b0;
                    end
                end
                mirror_count++;
                res.status = bmhq_pkg::STATUS_PUSHED;
            end
        end else begin
            if (mirror_count == 0) begin
                res.status = bmhq_pkg::STATUS_POP_EMPTY;
            end else begin
                res.key  = mirror_key[0];
                res.prio = 16'(mirror_prio[0]);
                mirror_count--;
                mirror_key[0]  = mirror_key[mirror_count];
                mirror_prio[0] = mirror_prio[mirror_count];
                // Sift down; the right child is looked at first so it wins a tie.
                pos = 0;
                moving = 1'b1;
                while (moving && pos < mirror_count) begin
                    best  = pos;
                    left  = 2 * pos + 1;
                    right = left + 1;
                    if (right < mirror_count && mirror_prio[right] < mirror_prio[best])
                        best = right;
                    if (left < mirror_count && mirror_prio[left] < mirror_prio[best])
                        best = left;
                    if (best == pos) begin
                        moving = 1'b0;
                    end else begin
                        mirror_swap(pos, best);
                        pos = best;
                    end
                end
                res.status = bmhq_pkg::STATUS_POPPED;
            end
        end
        res.fill = 11'(mirror_count);
        heap_results_due.push_back(res);
    endtask

    task automatic add_command(input logic cmd, input logic [15:0] key,
                               input logic [15:0] prio, input bit drain, input bit calm);
        command_t c;
        c.cmd         = cmd;
        c.key         = key;
        c.prio        = prio;
        c.drain_first = drain;
        c.no_gap      = calm;
        command_queue.push_back(c);
    endtask

    // Random phase: push share in percent and priority range set the heap's behavior.
    task automatic add_random_phase(input int count, input int push_pct, input int prio_max);
        bit calm;
        logic cmd;
        calm = 1'b0;
        for (int i = 0; i < count; i++) begin
            if (i % 25 == 0) calm = ($urandom_range(0, 3) == 0);
            cmd = ($urandom_range(0, 99) < push_pct) ? bmhq_pkg::CMD_PUSH : bmhq_pkg::CMD_POP;
            add_command(cmd, 16'($urandom), 16'($urandom_range(0, prio_max)), i == 0, calm);
        end
    endtask

    // Driver: presents queued command words, with random gaps between them.
    always @(posedge aclk) begin
        command_t c;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready)
                predict_heap_op(s_tuser[0], s_tdata[15:0], s_tdata[31:16]);
            if (s_tvalid && !s_tready) begin
                // Hold the word until it is taken.
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (command_queue.size() > 0 &&
                         !(command_queue[0].drain_first && heap_results_due.size() > 0)) begin
                c = command_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {c.prio, c.key};
                s_tuser  <= c.cmd;
                send_gap <= c.no_gap ? 0 : pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result word against the oldest prediction and stalls at random.
    always @(posedge aclk) begin
        heap_result_t exp_res;
        cycle_count <= cycle_count + 1;
        if (!aresetn) begin
            m_tready    <= 1'b0;
            ready_stall <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (heap_results_due.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected result word: tdata=%h tuser=%0d",
                                 m_tdata, m_tuser);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    exp_res = heap_results_due.pop_front();
                    if (m_tdata[15:0] !== exp_res.key || m_tdata[31:16] !== exp_res.prio ||
                        m_tdata[42:32] !== exp_res.fill || m_tuser !== exp_res.status) begin
                        if (mismatch_count < 10) begin
                            $display("result mismatch: expected key=%h prio=%h fill=%0d status=%0d",
                                     exp_res.key, exp_res.prio, exp_res.fill, exp_res.status);
                            $display("                 got      key=%h prio=%h fill=%0d status=%0d",
                                     m_tdata[15:0], m_tdata[31:16], m_tdata[42:32], m_tuser);
                        end
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (cycle_count % 300 == 0)
                ready_calm <= ($urandom_range(0, 3) == 0);
            if (ready_stall > 0) begin
                ready_stall <= ready_stall - 1;
                m_tready    <= 1'b0;
            end else if (!ready_calm && $urandom_range(0, 3) == 0) begin
                ready_stall <= pick_gap();
                m_tready    <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles in which neither side moves a word.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", idle_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        // Directed: empty pop, field extremes, equal priorities, last-entry pops.
        add_command(bmhq_pkg::CMD_POP,  16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        add_command(bmhq_pkg::CMD_PUSH, 16'h0000, 16'h0000, 1'b0, 1'b0);
        add_command(bmhq_pkg::CMD_PUSH, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
        add_command(bmhq_pkg::CMD_PUSH, 16'h1234, 16'h8000, 1'b0, 1'b0);
        for (int i = 1; i <= 4; i++)
            add_command(bmhq_pkg::CMD_PUSH, 16'hA000 + 16'(i), 16'h0100, 1'b0, 1'b1);
        add_command(bmhq_pkg::CMD_PUSH, 16'h5555, 16'h0001, 1'b0, 1'b0);
        add_command(bmhq_pkg::CMD_PUSH, 16'hAAAA, 16'hFFFF, 1'b0, 1'b0);
        for (int i = 0; i < 10; i++)
            add_command(bmhq_pkg::CMD_POP, 16'($urandom), 16'($urandom), 1'b0, i < 5);
        add_command(bmhq_pkg::CMD_PUSH, 16'hBEEF, 16'h7FFF, 1'b0, 1'b0);
        add_command(bmhq_pkg::CMD_POP,  16'h0000, 16'h0000, 1'b0, 1'b0);

        // Random: growing heap, shrinking heap, then many equal priorities.
        add_random_phase(150, 70, 16'hFFFF);
        add_random_phase(150, 30, 16'hFFFF);
        add_random_phase(130, 50, 7);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (!(command_queue.size() == 0 && !s_tvalid && heap_results_due.size() == 0))
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (heap_results_due.size() != 0)
            $display("%0d predicted results never arrived", heap_results_due.size());
        if (mismatch_count == 0 && heap_results_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
